FILE: hdl/base64_stream_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication
`define B64D_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

FILE: hdl/b64d_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character lookup of the base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] SYM_PAD = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_BAD_CHAR = 2'd2,
        STATUS_DANGLING = 2'd3
    } b64d_status_t;

    // one queue entry: one to three result words
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            valid_bytes;
        logic            msg_end;
        b64d_status_t    status;
    } b64d_group_t;

    // bit 6 set: not in the alphabet; bits 5:0: sextet value
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b0, 6'd63};
        end
        return r;
    endfunction

endpackage

FILE: hdl/b64d_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, packs sextets and builds groups of
// result words for the queue.
// ---------------------------------------------------------------------------
module b64d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] symbol
    input  logic                 s_axis_tlast,   // last_symbol
    output logic                 push,
    output b64d_pkg::b64d_group_t group_out,
    input  logic                 queue_full
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pad_reg, pad_next;
    logic        bad_reg, bad_next;

    logic        fire;
    logic        has_out;
    logic        complete;
    logic        active;
    logic [6:0]  lookup;
    logic [23:0] word;
    b64d_pkg::b64d_status_t status;

    assign s_axis_tready = !queue_full;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign push          = fire && has_out;

    always_comb begin
        lookup     = b64d_pkg::sextet_of(s_axis_tdata);
        active     = !pad_reg && !bad_reg;
        word       = {acc_reg, lookup[5:0]};
        phase_next = phase_reg + 2'd1;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        bad_next   = bad_reg;
        complete   = 1'b0;
        status     = b64d_pkg::STATUS_OK;

        if (active) begin
            if (s_axis_tdata == b64d_pkg::SYM_PAD) begin
                pad_next = 1'b1;
            end else if (lookup[6]) begin
                bad_next = 1'b1;
            end else if (cnt_reg == 2'd3) begin
                complete = 1'b1;
                acc_next = '0;
                cnt_next = '0;
            end else begin
                acc_next = {acc_reg[11:0], lookup[5:0]};
                cnt_next = cnt_reg + 2'd1;
            end
        end

        group_out.bytes[0]    = word[23:16];
        group_out.bytes[1]    = word[15:8];
        group_out.bytes[2]    = word[7:0];
        group_out.count       = 2'd3;
        group_out.valid_bytes = 1'b1;
        group_out.msg_end     = 1'b0;
        group_out.status      = b64d_pkg::STATUS_OK;
        has_out               = complete;

        if (s_axis_tlast) begin
            if (phase_next != 2'd0) begin
                status = b64d_pkg::STATUS_LENGTH;
            end else if (bad_next) begin
                status = b64d_pkg::STATUS_BAD_CHAR;
            end else if (cnt_next == 2'd1) begin
                status = b64d_pkg::STATUS_DANGLING;
            end

            has_out           = 1'b1;
            group_out.msg_end = 1'b1;
            group_out.status  = status;

            if (status != b64d_pkg::STATUS_OK) begin
                group_out.bytes       = '0;
                group_out.count       = 2'd1;
                group_out.valid_bytes = 1'b0;
            end else if (cnt_next == 2'd2) begin
                group_out.bytes    = '0;
                group_out.bytes[0] = acc_next[11:4];
                group_out.count    = 2'd1;
            end else if (cnt_next == 2'd3) begin
                group_out.bytes    = '0;
                group_out.bytes[0] = acc_next[17:10];
                group_out.bytes[1] = acc_next[9:2];
                group_out.count    = 2'd2;
            end else if (!complete) begin
                group_out.bytes       = '0;
                group_out.count       = 2'd1;
                group_out.valid_bytes = 1'b0;
            end

            acc_next   = '0;
            cnt_next   = '0;
            phase_next = '0;
            pad_next   = 1'b0;
            bad_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= '0;
            pad_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end else if (fire) begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

FILE: hdl/b64d_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_fifo
// Short queue of result groups between the front and back parts.
// ---------------------------------------------------------------------------
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  b64d_pkg::b64d_group_t wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output b64d_pkg::b64d_group_t rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::b64d_group_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hdl/b64d_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_back
// Sends queued groups out one result word a cycle while m_axis_tready is high.
// ---------------------------------------------------------------------------
module b64d_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b64d_pkg::b64d_group_t head,
    input  logic                  queue_empty,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [7:0] out_byte, [9:8] status
    output logic                  m_axis_tlast,   // message_end
    output logic                  m_axis_tuser    // byte_valid
);

    b64d_pkg::b64d_group_t cur_reg;
    logic                  cur_valid_reg;
    logic [1:0]            idx_reg;

    logic       final_word;
    logic       take;
    logic [7:0] byte_out;
    logic [1:0] status_out;

    assign final_word = (idx_reg == cur_reg.count - 2'd1);
    assign take       = !cur_valid_reg || (m_axis_tready && final_word);
    assign pop        = take && !queue_empty;

    always_comb begin
        case (idx_reg)
            2'd0:    byte_out = cur_reg.bytes[0];
            2'd1:    byte_out = cur_reg.bytes[1];
            2'd2:    byte_out = cur_reg.bytes[2];
            default: byte_out = '0;
        endcase
        status_out = final_word ? cur_reg.status : b64d_pkg::STATUS_OK;
    end

    assign m_axis_tvalid = cur_valid_reg;
    assign m_axis_tdata  = {6'd0, status_out, byte_out};
    assign m_axis_tlast  = cur_reg.msg_end && final_word;
    assign m_axis_tuser  = cur_reg.valid_bytes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (take) begin
            cur_valid_reg <= !queue_empty;
            idx_reg       <= '0;
        end else if (m_axis_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
    end

endmodule

FILE: hdl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// A character's results pass the group queue, then the back part's group register.
// Throughput: one character per cycle in, one result word per cycle out while
// m_axis_tready is high (the back part drains the queue at one word a cycle);
// s_axis_tready drops only while the group queue of QUEUE_DEPTH groups is full.
// Reset: synchronous, active low; clears the decoder state, queue and output.
// ---------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: characters in, decoded bytes and status out.
// ---------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // last_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status
    output logic        m_axis_tlast,   // message_end
    output logic        m_axis_tuser    // byte_valid
);

    b64d_pkg::b64d_group_t wr_group;
    b64d_pkg::b64d_group_t head_group;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;

    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .group_out     (wr_group),
        .queue_full    (queue_full)
    );

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (wr_group),
        .full    (queue_full),
        .rd_en   (pop),
        .rd_data (head_group),
        .empty   (queue_empty)
    );

    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head_group),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: hdl/base64_stream_decoder_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_checker
// Port-level checks on the result stream of the base64 decoder.
// ---------------------------------------------------------------------------
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    `B64D_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result word changed while stalled")
    `B64D_ASSERT_IMPL(a_status_on_end, m_axis_tvalid && m_axis_tdata[9:8] != b64d_pkg::STATUS_OK, m_axis_tlast, "status set on a word that does not end the message")
    `B64D_ASSERT_IMPL(a_error_no_byte, m_axis_tvalid && m_axis_tdata[9:8] != b64d_pkg::STATUS_OK, !m_axis_tuser, "error word carries a byte")
    `B64D_ASSERT_IMPL(a_empty_is_end, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && m_axis_tdata[7:0] == 8'd0, "word without a byte outside message end")

endmodule

bind base64_stream_decoder base64_stream_decoder_checker u_checker (.*);
